/* hdl/tlvw_pkg.sv */
// Shared types, codes and helpers for the TLV trailer area walker.
package tlvw_pkg;

	typedef struct packed {
		logic [7:0] data_byte;
		logic       start_of_area;
	} in_item_t;

	typedef struct packed {
		logic [1:0]  result_kind;
		logic [1:0]  status_code;
		logic [15:0] tlv_type;
		logic [15:0] tlv_length;
		logic [15:0] val_off;
		logic        last_of_run;
	} out_item_t;

	// result kinds
	localparam logic [1:0] KIND_RECORD = 2'd0;
	localparam logic [1:0] KIND_END    = 2'd1;
	localparam logic [1:0] KIND_ERROR  = 2'd2;

	// status codes
	localparam logic [1:0] ST_OK        = 2'd0;
	localparam logic [1:0] ST_TOO_SMALL = 2'd1;
	localparam logic [1:0] ST_BAD_MAGIC = 2'd2;
	localparam logic [1:0] ST_BAD_LEN   = 2'd3;

	// configuration register indexes
	localparam logic CFG_INFO_MAGIC  = 1'b0;
	localparam logic CFG_AREA_LENGTH = 1'b1;

	localparam int unsigned CFG_W = 16;

	function automatic out_item_t make_res(input logic [1:0] kind, input logic [1:0] status,
			input logic [15:0] ttype, input logic [15:0] tlen, input logic [15:0] toff);
		out_item_t r;
		r.result_kind  = kind;
		r.status_code  = status;
		r.tlv_type     = ttype;
		r.tlv_length   = tlen;
		r.val_off      = toff;
		r.last_of_run  = 1'b0;
		return r;
	endfunction

endpackage

/* hdl/tlvw_parse.sv */
// Walker state and per-byte parse logic: up to two results per byte.
module tlvw_parse
	import tlvw_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       fire,
	input  in_item_t   item,
	input  logic [15:0] magic_cfg,
	input  logic [15:0] area_length,
	output out_item_t  res0,
	output out_item_t  res1,
	output logic [1:0] res_cnt
);

	localparam logic [2:0] PH_IDLE   = 3'd0;
	localparam logic [2:0] PH_INFO   = 3'd1;
	localparam logic [2:0] PH_HEADER = 3'd2;
	localparam logic [2:0] PH_VALUE  = 3'd3;
	localparam logic [2:0] PH_DONE   = 3'd4;

	logic [15:0] pos_q, left_q, rstart_q;
	logic [23:0] hdr_q;
	logic [2:0]  phase_q;

	logic [15:0] pos_n, left_n, rstart_n;
	logic [23:0] hdr_n;
	logic [2:0]  phase_n;

	always_comb begin
		logic [1:0]  k;
		logic [15:0] lo, hi, rem;
		logic [16:0] nxt, bp, area17;
		logic        do_bnd, adv, err;
		logic [1:0]  err_st;
		logic [1:0]  cnt;
		out_item_t   r0, r1, rr;

		pos_n    = pos_q;
		left_n   = left_q;
		rstart_n = rstart_q;
		hdr_n    = hdr_q;
		phase_n  = phase_q;
		r0       = '0;
		r1       = '0;
		rr       = '0;
		cnt      = 2'd0;
		do_bnd   = 1'b0;
		adv      = 1'b0;
		err      = 1'b0;
		err_st   = ST_OK;
		bp       = '0;
		area17   = {1'b0, area_length};
		k        = 2'd0;
		lo       = '0;
		hi       = '0;
		rem      = '0;
		nxt      = '0;

		if (item.start_of_area) begin
			pos_n    = '0;
			hdr_n    = '0;
			left_n   = '0;
			rstart_n = '0;
			phase_n  = PH_INFO;
			if (area_length < 16'd4) begin
				err     = 1'b1;
				err_st  = ST_TOO_SMALL;
				phase_n = PH_DONE;
			end
		end

		case (phase_n)
			PH_INFO, PH_HEADER: begin
				adv = 1'b1;
				k   = pos_n[1:0] - rstart_n[1:0];
				lo  = hdr_n[15:0];
				hi  = {item.data_byte, hdr_n[23:16]};
				nxt = {1'b0, rstart_n} + 17'd4;
				if (k == 2'd0) begin
					hdr_n[7:0] = hdr_n[7:0] | item.data_byte;
				end else if (k == 2'd1) begin
					hdr_n[15:8] = hdr_n[15:8] | item.data_byte;
				end else if (k == 2'd2) begin
					hdr_n[23:16] = hdr_n[23:16] | item.data_byte;
				end else if (phase_n == PH_INFO) begin
					if (lo != magic_cfg) begin
						err    = 1'b1;
						err_st = ST_BAD_MAGIC;
					end else if (hi < 16'd4 || hi != area_length) begin
						err    = 1'b1;
						err_st = ST_BAD_LEN;
					end else begin
						do_bnd = 1'b1;
						bp     = 17'd4;
					end
				end else begin
					if (nxt > area17 || {1'b0, hi} > area17 - nxt) begin
						err    = 1'b1;
						err_st = ST_BAD_LEN;
					end else begin
						r0  = make_res(KIND_RECORD, ST_OK, lo, hi, nxt[15:0]);
						cnt = 2'd1;
						if (hi == 16'd0) begin
							do_bnd = 1'b1;
							bp     = nxt;
						end else begin
							phase_n = PH_VALUE;
							left_n  = hi;
						end
					end
				end
			end
			PH_VALUE: begin
				adv    = 1'b1;
				left_n = left_n - 16'd1;
				if (left_n == 16'd0) begin
					do_bnd = 1'b1;
					bp     = {1'b0, pos_n + 16'd1};
				end
			end
			default: begin
			end
		endcase

		// what follows a record that ends at offset bp
		if (do_bnd) begin
			rem = area_length - bp[15:0];
			if (bp > area17) begin
				err    = 1'b1;
				err_st = ST_BAD_LEN;
			end else if (rem == 16'd0) begin
				rr      = make_res(KIND_END, ST_OK, '0, '0, '0);
				phase_n = PH_DONE;
				if (cnt == 2'd0) r0 = rr;
				else r1 = rr;
				cnt = cnt + 2'd1;
			end else if (rem < 16'd4) begin
				err    = 1'b1;
				err_st = ST_BAD_LEN;
			end else begin
				phase_n  = PH_HEADER;
				rstart_n = bp[15:0];
				hdr_n    = '0;
			end
		end

		if (err) begin
			rr      = make_res(KIND_ERROR, err_st, '0, '0, '0);
			phase_n = PH_DONE;
			if (cnt == 2'd0) r0 = rr;
			else r1 = rr;
			cnt = cnt + 2'd1;
		end

		if (adv) pos_n = pos_n + 16'd1;

		r0.last_of_run = (cnt == 2'd1);
		r1.last_of_run = (cnt == 2'd2);
		res0    = r0;
		res1    = r1;
		res_cnt = cnt;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q    <= '0;
			left_q   <= '0;
			rstart_q <= '0;
			hdr_q    <= '0;
			phase_q  <= PH_IDLE;
		end else if (fire) begin
			pos_q    <= pos_n;
			left_q   <= left_n;
			rstart_q <= rstart_n;
			hdr_q    <= hdr_n;
			phase_q  <= phase_n;
		end
	end

	// two results only come from a record followed by its boundary outcome
	a_pair_starts_record: assert property (@(posedge clk) disable iff (!arst_n)
		(fire && res_cnt == 2'd2) |-> res0.result_kind == KIND_RECORD)
		else $error("second result without a record first");

	// any end or error parks the walker until the next start
	a_stop_after_final: assert property (@(posedge clk) disable iff (!arst_n)
		(fire && res_cnt != 2'd0 &&
		 ((res_cnt == 2'd1 && res0.result_kind != KIND_RECORD) || res_cnt == 2'd2))
		|=> phase_q == PH_DONE)
		else $error("walker kept going after end or error");

	// a value phase always has bytes left to skip
	a_value_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		phase_q == PH_VALUE |-> left_q != 16'd0)
		else $error("value phase with nothing left");

endmodule

/* hdl/tlvw_outq.sv */
// Four-entry result queue; takes up to two results per cycle, gives one.
module tlvw_outq
	import tlvw_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic [1:0] push_cnt,
	input  out_item_t  push0,
	input  out_item_t  push1,
	output logic       room,
	output logic       result_valid,
	input  logic       result_ready,
	output out_item_t  result
);

	out_item_t   ent_q [4];
	logic [1:0]  wr_q, rd_q;
	logic [2:0]  cnt_q;
	logic        pop;

	assign room         = (cnt_q <= 3'd2);
	assign result_valid = (cnt_q != 3'd0);
	assign result       = ent_q[rd_q];
	assign pop          = result_valid && result_ready;

	always_ff @(posedge clk) begin
		if (push_cnt != 2'd0) ent_q[wr_q] <= push0;
		if (push_cnt == 2'd2) ent_q[wr_q + 2'd1] <= push1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			wr_q  <= wr_q + push_cnt;
			if (pop) rd_q <= rd_q + 2'd1;
			cnt_q <= cnt_q + {1'b0, push_cnt} - {2'b0, pop};
		end
	end

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		push_cnt != 2'd0 |-> room)
		else $error("result queue overflow");

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= 3'd4)
		else $error("result queue count out of range");

endmodule

/* hdl/tlv_area_walker.sv */
// Top level of the TLV trailer area walker: input stage, config, parser, result queue.
//
//  port group      | dir | handshake                  | payload
//  ----------------+-----+----------------------------+-------------------------------
//  item            | in  | item_valid / item_ready    | in_item_t  (data_byte, start)
//  result          | out | result_valid / result_ready| out_item_t (kind .. last_of_run)
//  cfg             | in  | cfg_wen, no wait           | cfg_idx selects register, cfg_data
//
// One byte per cycle sustained while the queue has room. A byte is registered in
// stage 1 at its transfer, parsed there once the queue can take its results, then queued.
// Bytes that give two results (zero-length record at a boundary) give them out in
// turn; the 4-entry queue stalls input only when more than two results wait.
// Reset returns the walker to idle and loads the register defaults; no clearing pass.
// Result stalls back up through the queue to the input stage, one byte at a time.
module tlv_area_walker
	import tlvw_pkg::*;
(
	input  logic             clk,
	input  logic             arst_n,
	input  logic             item_valid,
	output logic             item_ready,
	input  in_item_t         item,
	output logic             result_valid,
	input  logic             result_ready,
	output out_item_t        result,
	input  logic             cfg_wen,
	input  logic             cfg_idx,
	input  logic [CFG_W-1:0] cfg_data
);

	// config registers
	logic [15:0] info_magic_q;
	logic [15:0] area_length_q;

	// input stage
	in_item_t item_s1;
	logic     valid_s1;
	logic     fire;
	logic     room;

	out_item_t  res0, res1;
	logic [1:0] res_cnt;

	// the parsed byte leaves stage 1 only when the queue can take both results
	assign fire       = valid_s1 && room;
	assign item_ready = !valid_s1 || fire;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			info_magic_q  <= 16'd26887;
			area_length_q <= 16'd0;
		end else if (cfg_wen) begin
			case (cfg_idx)
				CFG_INFO_MAGIC:  info_magic_q  <= cfg_data;
				CFG_AREA_LENGTH: area_length_q <= cfg_data;
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (item_ready) begin
			valid_s1 <= item_valid;
		end
	end

	// payload register, no reset needed
	always_ff @(posedge clk) begin
		if (item_ready && item_valid) item_s1 <= item;
	end

	tlvw_parse u_parse (
		.clk         (clk),
		.arst_n      (arst_n),
		.fire        (fire),
		.item        (item_s1),
		.magic_cfg   (info_magic_q),
		.area_length (area_length_q),
		.res0        (res0),
		.res1        (res1),
		.res_cnt     (res_cnt)
	);

	tlvw_outq u_outq (
		.clk          (clk),
		.arst_n       (arst_n),
		.push_cnt     (fire ? res_cnt : 2'd0),
		.push0        (res0),
		.push1        (res1),
		.room         (room),
		.result_valid (result_valid),
		.result_ready (result_ready),
		.result       (result)
	);

	// a byte waiting on a full queue keeps its slot and contents
	a_s1_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && !fire) |=> (valid_s1 && $stable(item_s1)))
		else $error("stage 1 byte lost while stalled");

endmodule

/* test/tb.sv */
// Testbench for the TLV trailer area walker: byte stimulus, walk predictor and result checks.
module tb;
	import tlvw_pkg::*;

	localparam int unsigned ITEMS        = 1500;
	localparam int unsigned CALM_TAIL    = 300;     // last bytes sent with no idling at all
	localparam int unsigned DRAIN_CYCLES = 8;       // byte register + parse + queue, with margin
	localparam int unsigned CYCLE_LIMIT  = 400000;
	localparam logic [15:0] MAGIC_AT_RESET = 16'd26887;

	typedef enum logic [2:0] {PH_IDLE, PH_INFO, PH_HEADER, PH_VALUE, PH_DONE} walk_phase_e;

	// Tracks the walk byte by byte and keeps the results still owed by the block.
	class tlv_walk_tracker;
		logic [15:0] magic, area_sz;
		logic [15:0] pos, rec_start, value_left;
		logic [23:0] hdr;
		walk_phase_e phase;
		out_item_t   byte_reports[$];
		out_item_t   awaited_reports[$];
		int unsigned fails, taken_bytes;

		function new();
			magic = MAGIC_AT_RESET;
			area_sz = '0;
			pos = '0;
			rec_start = '0;
			value_left = '0;
			hdr = '0;
			phase = PH_IDLE;
			fails = 0;
			taken_bytes = 0;
		endfunction

		function void set_reg(logic idx, logic [15:0] v);
			if (idx == CFG_INFO_MAGIC) magic = v;
			else area_sz = v;
		endfunction

		function void add_report(logic [1:0] kind, logic [1:0] st, logic [15:0] t,
				logic [15:0] l, logic [15:0] o);
			out_item_t r;
			r.result_kind  = kind;
			r.status_code  = st;
			r.tlv_type     = t;
			r.tlv_length   = l;
			r.val_off      = o;
			r.last_of_run  = 1'b0;
			byte_reports.push_back(r);
		endfunction

		function void stop_walk(logic [1:0] st);
			add_report(KIND_ERROR, st, '0, '0, '0);
			phase = PH_DONE;
		endfunction

		// a record (or the info record) has ended at offset p
		function void record_ends(int unsigned p);
			int unsigned rem, alen;
			alen = 32'(area_sz);
			if (p > alen) begin
				stop_walk(ST_BAD_LEN);
				return;
			end
			rem = alen - p;
			if (rem == 0) begin
				add_report(KIND_END, ST_OK, '0, '0, '0);
				phase = PH_DONE;
			end else if (rem < 4) begin
				stop_walk(ST_BAD_LEN);
			end else begin
				phase = PH_HEADER;
				rec_start = p[15:0];
				hdr = '0;
			end
		endfunction

		function void header_byte(logic [7:0] b);
			logic [15:0] span;
			int unsigned k, lo, hi, nxt, alen;
			span = pos - rec_start;
			k = 32'(span[1:0]);
			if (k < 3) begin
				hdr = hdr | (24'(b) << (8 * k));
				return;
			end
			lo = 32'(hdr[15:0]);
			hi = 32'({b, hdr[23:16]});
			nxt = rec_start + 4;
			alen = 32'(area_sz);
			if (phase == PH_INFO) begin
				if (lo != magic) stop_walk(ST_BAD_MAGIC);
				else if (hi < 4 || hi != alen) stop_walk(ST_BAD_LEN);
				else record_ends(4);
				return;
			end
			// header must fit and its value must not run past the area
			if (nxt > alen || hi > alen - nxt) begin
				stop_walk(ST_BAD_LEN);
				return;
			end
			add_report(KIND_RECORD, ST_OK, lo[15:0], hi[15:0], nxt[15:0]);
			if (hi == 0) record_ends(nxt);
			else begin
				phase = PH_VALUE;
				value_left = hi[15:0];
			end
		endfunction

		// one accepted byte: advance the walk and queue what it must produce
		function void walk_byte(in_item_t it);
			bit walked;
			logic [15:0] after_pos;
			out_item_t r;
			walked = 1'b0;
			byte_reports.delete();
			taken_bytes++;
			if (it.start_of_area) begin
				pos = '0;
				hdr = '0;
				value_left = '0;
				rec_start = '0;
				phase = PH_INFO;
				if (area_sz < 4) stop_walk(ST_TOO_SMALL);
				else walked = 1'b1;
			end else if (phase inside {PH_INFO, PH_HEADER, PH_VALUE}) begin
				walked = 1'b1;
			end
			if (walked) begin
				case (phase)
					PH_VALUE: begin
						value_left--;
						after_pos = pos + 16'd1;
						if (value_left == 0) record_ends(32'(after_pos));
					end
					default: header_byte(it.data_byte);
				endcase
				pos++;
			end
			foreach (byte_reports[i]) begin
				r = byte_reports[i];
				r.last_of_run = (i == byte_reports.size() - 1);
				awaited_reports.push_back(r);
			end
		endfunction

		function string show(out_item_t r);
			return $sformatf("kind=%0d status=%0d type=%h len=%h off=%h last=%b",
				r.result_kind, r.status_code, r.tlv_type, r.tlv_length, r.val_off,
				r.last_of_run);
		endfunction

		function void check_result(out_item_t got);
			out_item_t want;
			if (awaited_reports.size() == 0) begin
				fails++;
				if (fails <= 10) $display("unexpected result: %s", show(got));
				return;
			end
			want = awaited_reports.pop_front();
			if (got.result_kind !== want.result_kind || got.status_code !== want.status_code ||
					got.tlv_type !== want.tlv_type || got.tlv_length !== want.tlv_length ||
					got.val_off !== want.val_off ||
					got.last_of_run !== want.last_of_run) begin
				fails++;
				if (fails <= 10) begin
					$display("result mismatch, expected %s", show(want));
					$display("                 actual   %s", show(got));
				end
			end
		endfunction
	endclass

	logic             clk = 1'b0;
	logic             arst_n = 1'b0;
	logic             item_valid = 1'b0;
	logic             item_ready;
	in_item_t         item = '0;
	logic             result_valid;
	logic             result_ready = 1'b0;
	out_item_t        result;
	logic             cfg_wen = 1'b0;
	logic             cfg_idx = CFG_INFO_MAGIC;
	logic [CFG_W-1:0] cfg_data = '0;

	tlv_walk_tracker tracker = new();
	int unsigned idle_pct = 0;          // idling chance, shared by both sides
	int unsigned cycle_count = 0;
	logic [15:0] cur_magic = MAGIC_AT_RESET;
	logic [15:0] cur_len = '0;

	tlv_area_walker dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.item_valid   (item_valid),
		.item_ready   (item_ready),
		.item         (item),
		.result_valid (result_valid),
		.result_ready (result_ready),
		.result       (result),
		.cfg_wen      (cfg_wen),
		.cfg_idx      (cfg_idx),
		.cfg_data     (cfg_data)
	);

	always #4 clk = ~clk;

	// Both channels are sampled at the rising edge; the predictor runs on each byte transfer.
	always @(posedge clk) begin
		if (arst_n) begin
			if (item_valid && item_ready) tracker.walk_byte(item);
			if (result_valid && result_ready) tracker.check_result(result);
		end
	end

	// Result side: ready drops in random bursts while idling is on.
	initial begin
		int unsigned stall;
		stall = 0;
		forever begin
			@(negedge clk);
			if (stall == 0 && idle_pct != 0 && $urandom_range(0, 299) < idle_pct)
				stall = $urandom_range(1, 10);
			if (stall > 0) begin
				result_ready <= 1'b0;
				stall--;
			end else begin
				result_ready <= 1'b1;
			end
		end
	end

	// Hard stop if the block hangs.
	initial begin
		while (cycle_count < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("tb failed");
		$finish;
	end

	// One byte transfer, optionally preceded by an idle burst with junk on the payload.
	task automatic send_byte(input logic [7:0] b, input logic s);
		int unsigned gap;
		gap = 0;
		if (idle_pct != 0 && $urandom_range(0, 99) < idle_pct) gap = $urandom_range(1, 10);
		@(negedge clk);
		if (gap != 0) begin
			item_valid <= 1'b0;
			item <= '{data_byte: 8'($urandom), start_of_area: 1'b0};
			repeat (gap) @(negedge clk);
		end
		item_valid <= 1'b1;
		item <= '{data_byte: b, start_of_area: s};
		do @(posedge clk); while (!item_ready);
	endtask

	// little-endian 16-bit field
	task automatic send_word(input logic [15:0] w);
		send_byte(w[7:0], 1'b0);
		send_byte(w[15:8], 1'b0);
	endtask

	// info record: magic then declared total, first byte flagged as start
	task automatic send_info(input logic [15:0] m, input logic [15:0] total);
		send_byte(m[7:0], 1'b1);
		send_byte(m[15:8], 1'b0);
		send_word(total);
	endtask

	task automatic send_noise(input int unsigned n, input int unsigned start_pct);
		repeat (n) send_byte(8'($urandom), $urandom_range(0, 99) < start_pct);
	endtask

	// Stop sending, wait out every owed result, then let bytes with no result drain too.
	task automatic settle();
		@(negedge clk);
		item_valid <= 1'b0;
		while (tracker.awaited_reports.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(input logic idx, input logic [CFG_W-1:0] v);
		@(negedge clk);
		cfg_wen <= 1'b1;
		cfg_idx <= idx;
		cfg_data <= v;
		@(posedge clk);
		tracker.set_reg(idx, v);
		if (idx == CFG_INFO_MAGIC) cur_magic = v;
		else cur_len = v;
		@(negedge clk);
		cfg_wen <= 1'b0;
	endtask

	initial begin
		int unsigned r, len, rem, v, room, after;
		int budget;
		logic [15:0] m, tot;
		bit mid_change, walk_done, magic_change;

		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// ---- directed part ----
		idle_pct = 25;
		send_byte(8'hA5, 1'b0);                 // no start seen yet: ignored
		send_byte(8'h00, 1'b1);                 // area_length still 0 after reset: too small
		send_byte(8'hFF, 1'b0);                 // after an error: ignored
		settle();
		write_reg(CFG_INFO_MAGIC, 16'h0000);
		write_reg(CFG_AREA_LENGTH, 16'd8);
		send_info(16'h0000, 16'd8);
		send_word(16'hFFFF);                    // zero-length record ending on the area end:
		send_word(16'h0000);                    // record and end from the same byte
		settle();
		write_reg(CFG_INFO_MAGIC, 16'hFFFF);
		write_reg(CFG_AREA_LENGTH, 16'd6);
		send_info(16'hFFFF, 16'd6);             // two bytes left after info: trailing fragment
		send_info(16'hFEFF, 16'd6);             // magic off by one bit
		settle();
		write_reg(CFG_AREA_LENGTH, 16'd12);
		send_info(16'hFFFF, 16'd12);
		send_word(16'h8001);
		send_word(16'd5);                       // only 4 value bytes fit: overrun
		settle();
		write_reg(CFG_AREA_LENGTH, 16'hFFFF);
		send_info(16'hFFFF, 16'hFFFF);
		settle();
		write_reg(CFG_AREA_LENGTH, 16'd6);      // area shrinks under a walk in progress
		send_word(16'h0000);
		send_word(16'hFFFF);                    // header now ends past the area

		// ---- random part: mostly well-formed walks with random content ----
		while (tracker.taken_bytes < ITEMS) begin
			if (tracker.taken_bytes + CALM_TAIL >= ITEMS) idle_pct = 0;
			else begin
				case ($urandom_range(0, 2))
					0: idle_pct = 0;
					1: idle_pct = 10;
					default: idle_pct = 35;
				endcase
			end
			r = $urandom_range(0, 99);
			if (r < 75) begin
				r = $urandom_range(0, 99);
				if (r < 4) len = ($urandom_range(0, 1) != 0) ? 16'hFFFF : $urandom_range(4, 65535);
				else if (r < 30) len = cur_len;     // same setting: walks run back to back
				else len = $urandom_range(4, 60);
				magic_change = $urandom_range(0, 99) < 8;
				if (len != cur_len || magic_change) begin
					settle();
					if (len != cur_len) write_reg(CFG_AREA_LENGTH, 16'(len));
					if (magic_change) begin
						case ($urandom_range(0, 2))
							0: write_reg(CFG_INFO_MAGIC, 16'h0000);
							1: write_reg(CFG_INFO_MAGIC, 16'hFFFF);
							default: write_reg(CFG_INFO_MAGIC, 16'($urandom_range(0, 65535)));
						endcase
					end
				end

				// info record, sometimes broken
				m = cur_magic;
				tot = len[15:0];
				if ($urandom_range(0, 99) < 5) m ^= 16'd1 << $urandom_range(0, 15);
				if ($urandom_range(0, 99) < 5) begin
					if ($urandom_range(0, 1) != 0) tot = 16'($urandom_range(0, 3));
					else tot ^= 16'd1 << $urandom_range(0, 15);
				end
				send_info(m, tot);
				rem = (len >= 4) ? len - 4 : 0;
				walk_done = (m != cur_magic) || (tot != len) || (len < 4) || (rem > 0 && rem < 4);

				// records until the end, an error, or the byte budget runs out
				budget = 120;
				mid_change = $urandom_range(0, 99) < 8;
				while (!walk_done && rem >= 4 && budget > 0) begin
					room = rem - 4;
					r = $urandom_range(0, 99);
					if (r < 5) begin
						v = $urandom_range(room + 1, 65535);
						send_word(16'($urandom_range(0, 65535)));
						send_word(16'(v));
						walk_done = 1'b1;
					end else begin
						if (r < 20) v = 0;
						else if (r < 35 && room <= 200) v = room;
						else v = $urandom_range(0, (room < 40) ? room : 40);
						after = room - v;
						// usually avoid leaving a fragment; sometimes leave one on purpose
						if (after > 0 && after < 4 && $urandom_range(0, 99) < 70) begin
							v = room;
							after = 0;
						end
						send_word(16'($urandom_range(0, 65535)));
						send_word(16'(v));
						repeat (v) send_byte(8'($urandom), 1'b0);
						rem = after;
						budget = budget - 4 - int'(v);
						if (after > 0 && after < 4) begin
							walk_done = 1'b1;
						end else if (mid_change && $urandom_range(0, 3) == 0) begin
							settle();
							write_reg(CFG_AREA_LENGTH, 16'($urandom_range(0, len - rem)));
							send_noise($urandom_range(1, 12), 0);
							walk_done = 1'b1;
						end
					end
				end
				send_noise($urandom_range(0, 3), 0);
			end else if (r < 90) begin
				send_noise($urandom_range(1, 20), 15);
			end else begin
				settle();
				write_reg(CFG_AREA_LENGTH, 16'($urandom_range(0, 3)));
				send_byte(8'($urandom), 1'b1);
				send_noise($urandom_range(0, 3), 0);
			end
		end

		settle();
		repeat (20) @(posedge clk);
		if (tracker.fails == 0 && tracker.awaited_reports.size() == 0) $display("tb passed");
		else $display("tb failed");
		$finish;
	end

endmodule
